[src/warp_coalesced_memory_demand_core_assert.svh]
// ----------------------------------------------------------------------------
// warp coalesced memory demand assertion macros
// immediate-style wrappers around concurrent property checks on clk / rst_n
// ----------------------------------------------------------------------------
`ifndef WARP_COALESCED_MEMORY_DEMAND_CORE_ASSERT_SVH
`define WARP_COALESCED_MEMORY_DEMAND_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define WCMD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcmd assertion failed");

// next-cycle implication
`define WCMD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcmd assertion failed");

`else

`define WCMD_ASSERT_IMP(lbl, ante, cons)
`define WCMD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[src/wcmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcmd_pkg
// shared types, constants and helpers of the warp memory demand counter
// ----------------------------------------------------------------------------
package wcmd_pkg;

    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 5;
    localparam int EB_W    = 4;
    localparam int VEC_W   = 3;
    localparam int BYTES_W = 14;
    localparam int COST_W  = 9;
    localparam int CNT_W   = 8;
    localparam int MODE_W  = 2;
    localparam int LSB_W   = 4;
    localparam int SCALE_W = CNT_W + 3;
    localparam int TEX_W   = SCALE_W + VEC_W;

    localparam logic [MODE_W-1:0] MODE_EARLY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LATER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDEAL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_1B  = 5'd1;
    localparam logic [SIZE_W-1:0] SIZE_8B  = 5'd8;
    localparam logic [SIZE_W-1:0] SIZE_16B = 5'd16;

    localparam logic [COST_W-1:0] COST_256 = 9'd256;
    localparam logic [COST_W-1:0] COST_128 = 9'd128;
    localparam logic [COST_W-1:0] COST_64  = 9'd64;
    localparam logic [COST_W-1:0] COST_32  = 9'd32;

    localparam logic [EB_W-1:0] EB_1 = 4'd1;
    localparam logic [EB_W-1:0] EB_2 = 4'd2;
    localparam logic [EB_W-1:0] EB_4 = 4'd4;
    localparam logic [EB_W-1:0] EB_8 = 4'd8;

    localparam logic [BYTES_W-1:0] BYTE_MAX = 14'h3fff;
    localparam logic [CNT_W-1:0]   CNT_MAX  = 8'hff;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              lane_active;
        logic [SIZE_W-1:0] access_size;
        logic              is_texture;
        logic [EB_W-1:0]   texture_element_bytes;
        logic [VEC_W-1:0]  texture_vector;
        logic              last_lane;
    } item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] key;
        logic [COST_W-1:0] cost;
    } key_req_t;

    // active count times element bytes, element codes other than 1, 2, 4 and 8 give zero
    function automatic logic [SCALE_W-1:0] tex_scale(input logic [CNT_W-1:0] cnt,
                                                      input logic [EB_W-1:0] code);
        logic [SCALE_W-1:0] c;
        c = SCALE_W'(cnt);
        unique case (code)
            EB_1:    tex_scale = c;
            EB_2:    tex_scale = c << 1;
            EB_4:    tex_scale = c << 2;
            EB_8:    tex_scale = c << 3;
            default: tex_scale = '0;
        endcase
    endfunction

endpackage

[src/wcmd_key_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcmd_key_gen
// per-lane coalescing key and transaction cost for the selected rule
// ----------------------------------------------------------------------------
module wcmd_key_gen
    import wcmd_pkg::*;
#(
    parameter int HALF_WARP_LANES = 16
)
(
    input  logic [MODE_W-1:0]                  mode,
    input  logic [$clog2(HALF_WARP_LANES)-1:0] hpos,
    input  item_t                              item,
    output key_req_t                           req
);

    localparam int HPOS_W = $clog2(HALF_WARP_LANES);
    localparam int PROD_W = SIZE_W + HPOS_W;

    logic [ADDR_W-1:0] base;
    logic [PROD_W-1:0] prod;
    logic              on_stride;
    logic              nonzero;

    // base + size * hpos == address reduces to the low nibble check
    always_comb
    begin
        base      = {item.address[ADDR_W-1:LSB_W], {LSB_W{1'b0}}};
        prod      = PROD_W'(item.access_size) * PROD_W'(hpos);
        on_stride = (prod == PROD_W'(item.address[LSB_W-1:0]));
        nonzero   = |item.address;
    end

    always_comb
    begin
        req = '0;
        unique case (mode)
            MODE_EARLY:
            begin
                req.en  = item.lane_active && nonzero;
                req.key = on_stride ? base : item.address;
                if (item.access_size == SIZE_16B)
                    req.cost = COST_256;
                else if (item.access_size == SIZE_8B)
                    req.cost = COST_128;
                else
                    req.cost = COST_64;
            end
            MODE_LATER:
            begin
                req.en   = item.lane_active && nonzero;
                req.key  = base;
                req.cost = (item.access_size > SIZE_1B) ? COST_64 : COST_32;
            end
            MODE_IDEAL:
            begin
                req.en   = item.lane_active;
                req.key  = item.address;
                req.cost = COST_W'(item.access_size);
            end
            MODE_NONE:
            begin
                req.en   = 1'b0;
                req.key  = item.address;
                req.cost = '0;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

endmodule

[src/wcmd_key_cam.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcmd_key_cam
// key store with parallel match and insert at the first free entry
// ----------------------------------------------------------------------------
module wcmd_key_cam
    import wcmd_pkg::*;
#(
    parameter int WARP_LANES = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  logic     pre_clear,
    input  logic     post_clear,
    input  key_req_t req,
    output logic     inserted
);

    logic [ADDR_W-1:0]     key_reg [WARP_LANES];
    logic [WARP_LANES-1:0] valid_reg;
    logic [WARP_LANES-1:0] valid_next;
    logic [WARP_LANES-1:0] valid_eff;
    logic [WARP_LANES-1:0] hit_vec;
    logic [WARP_LANES-1:0] wr_sel;
    logic                  hit;

    // valid entries always form a prefix, so the first free one is a single edge
    always_comb
    begin
        valid_eff = pre_clear ? '0 : valid_reg;
        for (int i = 0; i < WARP_LANES; i++)
        begin
            hit_vec[i] = valid_eff[i] && (key_reg[i] == req.key);
            if (i == 0)
                wr_sel[i] = !valid_eff[i];
            else
                wr_sel[i] = !valid_eff[i] && valid_eff[i-1];
        end
        hit      = |hit_vec;
        inserted = req.en && !hit && !valid_eff[WARP_LANES-1];
        if (post_clear)
            valid_next = '0;
        else
            valid_next = valid_eff | (inserted ? wr_sel : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (step)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WARP_LANES; i++)
        begin
            if (step && inserted && wr_sel[i])
                key_reg[i] <= req.key;
        end
    end

endmodule

[src/warp_coalesced_memory_demand_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// warp_coalesced_memory_demand_core
// memory transaction byte count of one warp access, one lane per beat
// ----------------------------------------------------------------------------
// usage
//   lanes of a warp access enter in lane order on the in_valid / in_ready
//   channel, one beat per lane; the beat with last_lane set closes the access
//   one demand_bytes beat leaves on out_valid / out_ready per closing lane
//   a lane is registered at the input, then matched against the key store
//   and folded into the totals when it leaves the input register; out_valid
//   is registered and rises once the closing lane leaves the input register
//   throughput: one lane per cycle while no closing lane waits, bounded by the
//   combinational key store match-and-insert loop
//   coalescing_mode is set via cfg_wr_en / cfg_wr_data; the user must write
//   it only while idle, which the block does not enforce; reset clears the
//   mode, lane counters, key valid bits and totals at once; lanes are taken
//   straight after reset; a stalled result holds in the output register;
//   non-closing lanes keep flowing, a closing lane waits in the input register
//   until the result register frees up
// ----------------------------------------------------------------------------
`include "warp_coalesced_memory_demand_core_assert.svh"

module warp_coalesced_memory_demand_core
    import wcmd_pkg::*;
#(
    parameter int WARP_LANES      = 32,
    parameter int HALF_WARP_LANES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [MODE_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ADDR_W-1:0]  address,
    input  logic               lane_active,
    input  logic [SIZE_W-1:0]  access_size,
    input  logic               is_texture,
    input  logic [EB_W-1:0]    texture_element_bytes,
    input  logic [VEC_W-1:0]   texture_vector,
    input  logic               last_lane,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTES_W-1:0] demand_bytes
);

    localparam int LP_W = $clog2(WARP_LANES);
    localparam int HP_W = $clog2(HALF_WARP_LANES);
    localparam logic [LP_W-1:0] LANE_LAST = LP_W'(WARP_LANES - 1);
    localparam logic [HP_W-1:0] HALF_LAST = HP_W'(HALF_WARP_LANES - 1);

    logic [MODE_W-1:0]  mode_reg;
    item_t              item_reg;
    logic               item_valid_reg;
    logic [LP_W-1:0]    lane_pos_reg;
    logic [LP_W-1:0]    lane_pos_next;
    logic [HP_W-1:0]    hpos_reg;
    logic [HP_W-1:0]    hpos_next;
    logic [BYTES_W-1:0] total_reg;
    logic [BYTES_W-1:0] total_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic [BYTES_W-1:0] demand_reg;
    logic [BYTES_W-1:0] demand_next;

    logic               out_free;
    logic               step;
    logic               close_step;
    logic               close_wait;
    logic               wrap_step;
    logic               access_clear;
    logic               pre_clear;
    logic               post_clear;
    logic               wrap;
    logic               inserted;
    key_req_t           req;
    logic [BYTES_W:0]   sum;
    logic [BYTES_W-1:0] total_add;
    logic [CNT_W-1:0]   count_add;
    logic [TEX_W-1:0]   tex_prod;
    logic [BYTES_W-1:0] tex_bytes;

    assign out_free = !out_valid_reg || out_ready;
    assign step     = item_valid_reg && (!item_reg.last_lane || out_free);
    assign in_ready = !item_valid_reg || step;

    assign close_step   = step && item_reg.last_lane;
    assign close_wait   = item_valid_reg && item_reg.last_lane && !out_free;
    assign wrap_step    = step && !item_reg.last_lane && wrap;
    assign access_clear = (lane_pos_reg == '0) && (hpos_reg == '0) && (total_reg == '0);

    assign pre_clear  = (mode_reg == MODE_EARLY || mode_reg == MODE_LATER) && (hpos_reg == '0);
    assign wrap       = (lane_pos_reg == LANE_LAST);
    assign post_clear = item_reg.last_lane || wrap;

    wcmd_key_gen #(
        .HALF_WARP_LANES (HALF_WARP_LANES)
    ) u_key_gen (
        .mode (mode_reg),
        .hpos (hpos_reg),
        .item (item_reg),
        .req  (req)
    );

    wcmd_key_cam #(
        .WARP_LANES (WARP_LANES)
    ) u_key_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pre_clear  (pre_clear),
        .post_clear (post_clear),
        .req        (req),
        .inserted   (inserted)
    );

    always_comb
    begin
        sum       = {1'b0, total_reg} + (BYTES_W + 1)'(req.cost);
        total_add = inserted ? (sum[BYTES_W] ? BYTE_MAX : sum[BYTES_W-1:0]) : total_reg;
        count_add = (item_reg.lane_active && count_reg != CNT_MAX) ? count_reg + 1'b1
                                                                    : count_reg;
        tex_prod  = TEX_W'(tex_scale(count_add, item_reg.texture_element_bytes))
                    * TEX_W'(item_reg.texture_vector);
        tex_bytes = (tex_prod > TEX_W'(BYTE_MAX)) ? BYTE_MAX : tex_prod[BYTES_W-1:0];
        demand_next = item_reg.is_texture ? tex_bytes : total_add;

        if (item_reg.last_lane)
        begin
            lane_pos_next = '0;
            hpos_next     = '0;
            total_next    = '0;
            count_next    = '0;
        end
        else
        begin
            lane_pos_next = wrap ? '0 : lane_pos_reg + 1'b1;
            hpos_next     = (wrap || hpos_reg == HALF_LAST) ? '0 : hpos_reg + 1'b1;
            total_next    = total_add;
            count_next    = count_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_EARLY;
            item_valid_reg <= 1'b0;
            lane_pos_reg   <= '0;
            hpos_reg       <= '0;
            total_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (in_ready)
                item_valid_reg <= in_valid;
            if (step)
            begin
                lane_pos_reg <= lane_pos_next;
                hpos_reg     <= hpos_next;
                total_reg    <= total_next;
                count_reg    <= count_next;
            end
            if (close_step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.address               <= address;
            item_reg.lane_active           <= lane_active;
            item_reg.access_size           <= access_size;
            item_reg.is_texture            <= is_texture;
            item_reg.texture_element_bytes <= texture_element_bytes;
            item_reg.texture_vector        <= texture_vector;
            item_reg.last_lane             <= last_lane;
        end
        if (close_step)
            demand_reg <= demand_next;
    end

    assign out_valid    = out_valid_reg;
    assign demand_bytes = demand_reg;

    `WCMD_ASSERT_IMP(a_last_waits_for_slot, close_wait, !in_ready)
    `WCMD_ASSERT_NXT(a_last_gives_result, close_step, out_valid_reg)
    `WCMD_ASSERT_NXT(a_last_restarts_access, close_step, access_clear)
    `WCMD_ASSERT_NXT(a_overlong_wraps, wrap_step, lane_pos_reg == '0 && hpos_reg == '0)

endmodule
